>>> rtl/core/cas_pkg.sv
`default_nettype none

package cas_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and register widths
  localparam int SIZE_W = 11;
  localparam int POP_W  = 4;
  localparam int CNT_W  = 4;

  localparam int COL_W = $clog2(MAX_WIDTH);
  // Row counter reaches at most MAX_HEIGHT + 1 before the frame restarts
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int DIM_A = (SIZE_W > ROW_W) ? SIZE_W : ROW_W;
  localparam int DIM_W = (DIM_A > COL_W + 1) ? DIM_A : COL_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_UNDER_POP   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_OVER_POP    = REG_IDX_W'(3);

  localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = SIZE_W'(80);
  localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = SIZE_W'(50);
  localparam logic [POP_W-1:0]  UNDER_POP_RST   = POP_W'(2);
  localparam logic [POP_W-1:0]  OVER_POP_RST    = POP_W'(5);

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // One classified beat passed from front to back
  typedef struct packed {
    logic             wall;
    logic [COL_W-1:0] col;
    logic             has_res;
    logic             m_left;
    logic             m_right;
    logic             m_top;
    logic             m_bottom;
    logic             last;
  } cas_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [SIZE_W-1:0] v,
                                                  logic [DIM_W-1:0]  hi);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    if (x < DIM_W'(2)) begin
      return DIM_W'(2);
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cave_automaton_smoothing_step.sv
// Throughput: one beat per cycle in steady state while the output is not stalled, cells and flush beats alike.
// Path: a beat that releases a result passes the queue and the stage register, and
//   the result is then registered in the output register; that beat trails its cell by one row plus one cell.
// Reset: configuration returns to 80 x 50, limits 2 and 5; the row store is then
//   swept to zero, entry by entry, with in_stall_o high throughout.
`default_nettype none

module cave_automaton_smoothing_step (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cas_pkg::PADDR_W-1:0] paddr,
  input  wire logic [cas_pkg::PDATA_W-1:0] pwdata,
  output logic [cas_pkg::PDATA_W-1:0]      prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       kind_i,
  input  wire logic                       is_wall_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            new_is_wall_o,
  output logic [cas_pkg::CNT_W-1:0]       neighbour_walls_o,
  output logic                            frame_last_o
);
  import cas_pkg::*;

  logic [SIZE_W-1:0]    grid_width_q, grid_height_q;
  logic [POP_W-1:0]     under_pop_q, over_pop_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  cas_item_t            f_item, q_head;
  logic                 push, pop, q_empty, q_full, clr_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      under_pop_q   <= UNDER_POP_RST;
      over_pop_q    <= OVER_POP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[SIZE_W-1:0];
        REG_UNDER_POP:   under_pop_q   <= pwdata[POP_W-1:0];
        REG_OVER_POP:    over_pop_q    <= pwdata[POP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_q);
      REG_UNDER_POP:   prdata = PDATA_W'(under_pop_q);
      REG_OVER_POP:    prdata = PDATA_W'(over_pop_q);
      default:         prdata = '0;
    endcase
  end

  cas_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .is_wall_i     (is_wall_i),
    .clr_busy_i    (clr_busy),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (f_item)
  );

  cas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cas_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .under_pop_i       (under_pop_q),
    .over_pop_i        (over_pop_q),
    .head_i            (q_head),
    .empty_i           (q_empty),
    .pop_o             (pop),
    .clr_busy_o        (clr_busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .new_is_wall_o     (new_is_wall_o),
    .neighbour_walls_o (neighbour_walls_o),
    .frame_last_o      (frame_last_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/cas_front.sv
`default_nettype none

module cas_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [cas_pkg::SIZE_W-1:0] grid_width_i,
  input  wire logic [cas_pkg::SIZE_W-1:0] grid_height_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      kind_i,
  input  wire logic                      is_wall_i,
  input  wire logic                      clr_busy_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output cas_pkg::cas_item_t             item_o
);
  import cas_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [DIM_W-1:0] w, h, colx, rowx, c, oc, orow, nc;
  logic             cond, drop, last, accept;

  assign in_stall_o = clr_busy_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = accept;

  always_comb begin
    w    = clamp_dim(grid_width_i, MAX_W_D);
    h    = clamp_dim(grid_height_i, MAX_H_D);
    colx = DIM_W'(col_q);
    rowx = DIM_W'(row_q);
    // a column left over from a wider grid starts over at zero
    c    = (colx >= w) ? '0 : colx;
    cond = (rowx >= DIM_W'(2)) || ((rowx == DIM_W'(1)) && (c != '0));
    if (c != '0) begin
      oc   = c - DIM_W'(1);
      orow = rowx - DIM_W'(1);
    end else begin
      oc   = w - DIM_W'(1);
      orow = rowx - DIM_W'(2);
    end
    drop = orow >= h;
    last = (orow == h - DIM_W'(1)) && (oc == w - DIM_W'(1));
    nc   = c + DIM_W'(1);

    if (cond && (drop || last)) begin
      col_d = '0;
      row_d = '0;
    end else if (nc >= w) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = COL_W'(nc);
      row_d = row_q;
    end

    item_o.wall     = (kind_i == KIND_FLUSH) ? 1'b0 : is_wall_i;
    item_o.col      = COL_W'(c);
    item_o.has_res  = cond & ~drop;
    item_o.m_left   = (oc == '0);
    item_o.m_right  = (oc == w - DIM_W'(1));
    item_o.m_top    = (orow == '0);
    item_o.m_bottom = (orow == h - DIM_W'(1));
    item_o.last     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cas_queue.sv
`default_nettype none

module cas_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cas_pkg::cas_item_t item_i,
  input  wire logic               pop_i,
  output cas_pkg::cas_item_t      head_o,
  output logic                    empty_o,
  output logic                    full_o
);
  import cas_pkg::*;

  cas_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cas_back.sv
`default_nettype none

module cas_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [cas_pkg::POP_W-1:0] under_pop_i,
  input  wire logic [cas_pkg::POP_W-1:0] over_pop_i,
  input  wire cas_pkg::cas_item_t        head_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           clr_busy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           new_is_wall_o,
  output logic [cas_pkg::CNT_W-1:0]      neighbour_walls_o,
  output logic                           frame_last_o
);
  import cas_pkg::*;

  localparam logic [8:0] MASK_CENTER = 9'h010;
  localparam logic [8:0] MASK_LEFT   = 9'h1C0;
  localparam logic [8:0] MASK_RIGHT  = 9'h007;
  localparam logic [8:0] MASK_TOP    = 9'h049;
  localparam logic [8:0] MASK_BOTTOM = 9'h124;

  // Row store: bit0 newest cell of the column, bit1 the one above it
  logic [1:0]       mem [MAX_WIDTH];
  logic [1:0]       rd_q;
  logic             rd_en, wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [1:0]       wr_data;

  logic             clr_busy_q;
  logic [COL_W-1:0] clr_addr_q;

  cas_item_t        a_q;
  logic             a_v_q, a_fire;
  logic             fwd_q;
  logic [1:0]       fwd_d_q;

  logic [8:0]       win_q, win_d, mask, bits;
  logic [1:0]       e;
  logic [CNT_W-1:0] cnt;

  logic             out_v_q, out_wall_q, out_last_q;
  logic [CNT_W-1:0] out_cnt_q;

  assign clr_busy_o = clr_busy_q;

  assign a_fire = a_v_q & (~a_q.has_res | ~out_v_q | ~out_stall_i);
  assign pop_o  = ~empty_i & (~a_v_q | a_fire);
  assign rd_en  = pop_o;

  always_comb begin
    // take the row entry written on the edge the read was issued
    e     = fwd_q ? fwd_d_q : rd_q;
    win_d = {win_q[5:0], a_q.wall, e[0], e[1]};
    mask  = ~MASK_CENTER;
    if (a_q.m_left) begin
      mask = mask & ~MASK_LEFT;
    end
    if (a_q.m_right) begin
      mask = mask & ~MASK_RIGHT;
    end
    if (a_q.m_top) begin
      mask = mask & ~MASK_TOP;
    end
    if (a_q.m_bottom) begin
      mask = mask & ~MASK_BOTTOM;
    end
    bits = win_d & mask;
    cnt  = '0;
    for (int k = 0; k < 9; k++) begin
      cnt = cnt + CNT_W'(bits[k]);
    end

    wr_en   = clr_busy_q | a_fire;
    wr_addr = clr_busy_q ? clr_addr_q : a_q.col;
    wr_data = clr_busy_q ? 2'b00 : {e[0], a_q.wall};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[head_i.col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q     <= head_i;
      fwd_d_q <= wr_data;
    end
    if (a_fire && a_q.has_res) begin
      out_wall_q <= (cnt <= under_pop_i) || (cnt > over_pop_i);
      out_cnt_q  <= cnt;
      out_last_q <= a_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      a_v_q      <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      // sweep the row store once after reset
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + COL_W'(1);
        if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (pop_o) begin
        a_v_q <= 1'b1;
        fwd_q <= a_fire && (a_q.col == head_i.col);
      end else if (a_fire) begin
        a_v_q <= 1'b0;
      end
      if (a_fire) begin
        win_q <= win_d;
      end
      if (a_fire && a_q.has_res) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_v_q;
  assign new_is_wall_o     = out_wall_q;
  assign neighbour_walls_o = out_cnt_q;
  assign frame_last_o      = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/cas_checker.sv
`default_nettype none

module cas_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       new_is_wall_o,
  input wire logic [cas_pkg::CNT_W-1:0]  neighbour_walls_o,
  input wire logic                       frame_last_o
);
  import cas_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(new_is_wall_o) &&
      $stable(neighbour_walls_o) && $stable(frame_last_o))
    else $error("stalled result beat changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> neighbour_walls_o <= CNT_W'(8))
    else $error("neighbour count above eight");

  // The final cell is a corner: at most three neighbours lie in the grid
  a_corner_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> neighbour_walls_o <= CNT_W'(3))
    else $error("corner cell counted more than three neighbours");

  // The row store sweep keeps the input stalled right after reset
  a_reset_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open or result shown right after reset");

endmodule

bind cave_automaton_smoothing_step cas_checker u_cas_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .new_is_wall_o     (new_is_wall_o),
  .neighbour_walls_o (neighbour_walls_o),
  .frame_last_o      (frame_last_o)
);

`default_nettype wire
